// ===== rtl/complex_arith_unit_macros.svh =====
// assertion macros for the complex arithmetic unit checker
// sampled on clk, disabled while rst_n is low
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// implication checked at every clock edge
`define CAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arith_unit: implication check failed");

// condition that holds at every clock edge
`define CAU_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("complex_arith_unit: invariant check failed");

`endif

// ===== rtl/cau_pkg.sv =====
// shared types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // operation codes
    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4,
        ACT_CMP  = 3'd5
    } action_t;

    // flags that travel beside the divider chain
    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic eq;
        logic sat;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } side_t;

    // edges from an accepted beat to the sample of its result strobe
    function automatic int latency(input int dw);
        return dw + 5;
    endfunction

endpackage

// ===== rtl/complex_arith_unit.sv =====
// top level of the complex arithmetic unit: operand stages, divider cell chain, output
// depends on cau_pkg and cau_div_cell
//
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------------
//  command  | start / busy   | action, a_real, a_imag, b_real, b_imag
//  result   | done strobe    | result_real, result_imag, is_equal, div_by_zero,
//           |                | saturated
//
// one beat accepted per cycle; busy stays low, the pipeline never stalls
// the path is three operand stages, DATA_WIDTH + 1 divider
// cells (one quotient bit each) and the output register
// every operation takes the same path length so results leave in order
// rst_n clears the valid bits and side flags only; the receiver cannot stall, done lasts one cycle
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   action,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result_real,
    output logic signed [DATA_WIDTH-1:0] result_imag,
    output logic                         is_equal,
    output logic                         div_by_zero,
    output logic                         saturated
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * DW;
    localparam int QW = DW + 1;
    localparam int NW = PW + F;
    localparam int RW = NW - QW;
    localparam int CW = (RW > PW) ? RW : PW;

    localparam logic signed [PW:0] VMAX_W = signed'({{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}});
    localparam logic signed [PW:0] VMIN_W = ~VMAX_W;
    localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QW-1:0] LIM_POS = QW'(VMAX);
    localparam logic [QW-1:0] LIM_NEG = QW'(VMIN);

    // clamp a wide signed value, top bit of the result is the clamp flag
    function automatic logic [DW:0] clamp(input logic signed [PW:0] x);
        logic [DW:0] r;
        if (x > VMAX_W)
            r = {1'b1, VMAX};
        else if (x < VMIN_W)
            r = {1'b1, VMIN};
        else
            r = {1'b0, DW'(x)};
        return r;
    endfunction

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // stage 1: products and the simple operations
    logic                 s1_valid_reg;
    action_t              s1_act_reg;
    logic signed [PW-1:0] s1_arbr_reg, s1_aibi_reg, s1_aibr_reg, s1_biar_reg;
    logic signed [PW-1:0] s1_brbr_reg, s1_bibi_reg;
    logic [DW-1:0]        s1_re_reg, s1_im_reg;
    logic                 s1_eq_reg, s1_sat_reg;

    logic signed [PW-1:0] p_arbr, p_aibi, p_aibr, p_biar, p_brbr, p_bibi;
    logic signed [DW:0]   sum_re, sum_im, dif_re, dif_im, neg_ai;
    logic [DW:0]          c_re, c_im;
    logic [DW-1:0]        s1_re_next, s1_im_next;
    logic                 s1_eq_next, s1_sat_next;

    assign p_arbr = a_real * b_real;
    assign p_aibi = a_imag * b_imag;
    assign p_aibr = a_imag * b_real;
    assign p_biar = b_imag * a_real;
    assign p_brbr = b_real * b_real;
    assign p_bibi = b_imag * b_imag;

    always_comb
    begin
        sum_re      = (DW+1)'(a_real) + (DW+1)'(b_real);
        sum_im      = (DW+1)'(a_imag) + (DW+1)'(b_imag);
        dif_re      = (DW+1)'(a_real) - (DW+1)'(b_real);
        dif_im      = (DW+1)'(a_imag) - (DW+1)'(b_imag);
        neg_ai      = -(DW+1)'(a_imag);
        c_re        = '0;
        c_im        = '0;
        s1_eq_next  = 1'b0;
        unique case (action_t'(action))
            ACT_ADD:
            begin
                c_re = clamp((PW+1)'(sum_re));
                c_im = clamp((PW+1)'(sum_im));
            end
            ACT_SUB:
            begin
                c_re = clamp((PW+1)'(dif_re));
                c_im = clamp((PW+1)'(dif_im));
            end
            ACT_CONJ:
            begin
                c_re = {1'b0, a_real};
                c_im = clamp((PW+1)'(neg_ai));
            end
            ACT_CMP:
            begin
                s1_eq_next = (a_real == b_real) && (a_imag == b_imag);
            end
            default:
            begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        s1_re_next  = c_re[DW-1:0];
        s1_im_next  = c_im[DW-1:0];
        s1_sat_next = c_re[DW] | c_im[DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_act_reg  <= action_t'(action);
        s1_arbr_reg <= p_arbr;
        s1_aibi_reg <= p_aibi;
        s1_aibr_reg <= p_aibr;
        s1_biar_reg <= p_biar;
        s1_brbr_reg <= p_brbr;
        s1_bibi_reg <= p_bibi;
        s1_re_reg   <= s1_re_next;
        s1_im_reg   <= s1_im_next;
        s1_eq_reg   <= s1_eq_next;
        s1_sat_reg  <= s1_sat_next;
    end

    // stage 2: sums of products and the divisor
    logic               s2_valid_reg;
    action_t            s2_act_reg;
    logic signed [PW:0] s2_mul_re_reg, s2_mul_im_reg, s2_num_re_reg, s2_num_im_reg;
    logic [PW-1:0]      s2_den_reg;
    logic [DW-1:0]      s2_re_reg, s2_im_reg;
    logic               s2_eq_reg, s2_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_act_reg    <= s1_act_reg;
        s2_mul_re_reg <= (PW+1)'(s1_arbr_reg) - (PW+1)'(s1_aibi_reg);
        s2_mul_im_reg <= (PW+1)'(s1_aibr_reg) + (PW+1)'(s1_biar_reg);
        s2_num_re_reg <= (PW+1)'(s1_arbr_reg) + (PW+1)'(s1_aibi_reg);
        s2_num_im_reg <= (PW+1)'(s1_aibr_reg) - (PW+1)'(s1_biar_reg);
        s2_den_reg    <= $unsigned(s1_brbr_reg) + $unsigned(s1_bibi_reg);
        s2_re_reg     <= s1_re_reg;
        s2_im_reg     <= s1_im_reg;
        s2_eq_reg     <= s1_eq_reg;
        s2_sat_reg    <= s1_sat_reg;
    end

    // stage 3: multiply truncation, divide setup and overflow check
    side_t         s3_side_reg;
    logic [DW-1:0] s3_re_reg, s3_im_reg;
    logic [PW-1:0] s3_den_reg, s3_rem_re_reg, s3_rem_im_reg;
    logic [QW-1:0] s3_low_re_reg, s3_low_im_reg;

    side_t              s3_side_next;
    logic [DW-1:0]      s3_re_next, s3_im_next;
    logic [DW:0]        m_re, m_im;
    logic signed [PW:0] sh_re, sh_im;
    logic               n_re, n_im;
    logic [PW-1:0]      mag_re, mag_im;
    logic [NW-1:0]      big_re, big_im;
    logic [CW-1:0]      r0_re, r0_im;
    logic               is_div;

    always_comb
    begin
        sh_re  = s2_mul_re_reg >>> F;
        sh_im  = s2_mul_im_reg >>> F;
        m_re   = clamp(sh_re);
        m_im   = clamp(sh_im);
        n_re   = s2_num_re_reg[PW];
        n_im   = s2_num_im_reg[PW];
        mag_re = PW'($unsigned(n_re ? -s2_num_re_reg : s2_num_re_reg));
        mag_im = PW'($unsigned(n_im ? -s2_num_im_reg : s2_num_im_reg));
        big_re = NW'(mag_re) << F;
        big_im = NW'(mag_im) << F;
        r0_re  = CW'(big_re[NW-1:QW]);
        r0_im  = CW'(big_im[NW-1:QW]);
        is_div = (s2_act_reg == ACT_DIV);

        s3_side_next        = '0;
        s3_side_next.valid  = s2_valid_reg;
        s3_side_next.eq     = s2_eq_reg;
        s3_side_next.neg_re = n_re;
        s3_side_next.neg_im = n_im;
        s3_side_next.ovf_re = r0_re >= CW'(s2_den_reg);
        s3_side_next.ovf_im = r0_im >= CW'(s2_den_reg);
        s3_re_next          = s2_re_reg;
        s3_im_next          = s2_im_reg;
        s3_side_next.sat    = s2_sat_reg;
        if (s2_act_reg == ACT_MUL)
        begin
            s3_re_next       = m_re[DW-1:0];
            s3_im_next       = m_im[DW-1:0];
            s3_side_next.sat = m_re[DW] | m_im[DW];
        end
        else if (is_div)
        begin
            s3_re_next = '0;
            s3_im_next = '0;
            if (s2_den_reg == '0)
                s3_side_next.dz = 1'b1;
            else
                s3_side_next.is_div = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_side_reg <= '0;
        else
            s3_side_reg <= s3_side_next;
    end

    always_ff @(posedge clk)
    begin
        s3_re_reg     <= s3_re_next;
        s3_im_reg     <= s3_im_next;
        s3_den_reg    <= s2_den_reg;
        s3_rem_re_reg <= PW'(r0_re);
        s3_rem_im_reg <= PW'(r0_im);
        s3_low_re_reg <= big_re[QW-1:0];
        s3_low_im_reg <= big_im[QW-1:0];
    end

    // divider chain, one quotient bit per cell
    logic [PW-1:0] c_den    [QW+1];
    logic [PW-1:0] c_rem_re [QW+1];
    logic [PW-1:0] c_rem_im [QW+1];
    logic [QW-1:0] c_low_re [QW+1];
    logic [QW-1:0] c_low_im [QW+1];
    logic [QW-1:0] c_quo_re [QW+1];
    logic [QW-1:0] c_quo_im [QW+1];

    assign c_den[0]    = s3_den_reg;
    assign c_rem_re[0] = s3_rem_re_reg;
    assign c_rem_im[0] = s3_rem_im_reg;
    assign c_low_re[0] = s3_low_re_reg;
    assign c_low_im[0] = s3_low_im_reg;
    assign c_quo_re[0] = '0;
    assign c_quo_im[0] = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cau_div_cell #(
            .PW(PW),
            .QW(QW)
        ) u_cell (
            .clk        (clk),
            .den_in     (c_den[i]),
            .rem_re_in  (c_rem_re[i]),
            .rem_im_in  (c_rem_im[i]),
            .low_re_in  (c_low_re[i]),
            .low_im_in  (c_low_im[i]),
            .quo_re_in  (c_quo_re[i]),
            .quo_im_in  (c_quo_im[i]),
            .den_out    (c_den[i+1]),
            .rem_re_out (c_rem_re[i+1]),
            .rem_im_out (c_rem_im[i+1]),
            .low_re_out (c_low_re[i+1]),
            .low_im_out (c_low_im[i+1]),
            .quo_re_out (c_quo_re[i+1]),
            .quo_im_out (c_quo_im[i+1])
        );
    end

    // side line that keeps flags and non-divide results aligned with the chain
    side_t         side_reg [QW];
    logic [DW-1:0] sre_reg  [QW];
    logic [DW-1:0] sim_reg  [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                side_reg[k] <= '0;
        end
        else
        begin
            side_reg[0] <= s3_side_reg;
            for (int k = 1; k < QW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sre_reg[0] <= s3_re_reg;
        sim_reg[0] <= s3_im_reg;
        for (int k = 1; k < QW; k++)
        begin
            sre_reg[k] <= sre_reg[k-1];
            sim_reg[k] <= sim_reg[k-1];
        end
    end

    // quotient sign, saturation and output select
    side_t         tail;
    logic          dsat_re, dsat_im;
    logic [QW-1:0] q_re, q_im;
    logic [DW-1:0] dq_re, dq_im;
    logic          done_next, eq_next, dz_next, sat_next;
    logic [DW-1:0] re_next, im_next;

    always_comb
    begin
        tail    = side_reg[QW-1];
        q_re    = c_quo_re[QW];
        q_im    = c_quo_im[QW];
        dsat_re = tail.ovf_re || (q_re > (tail.neg_re ? LIM_NEG : LIM_POS));
        dsat_im = tail.ovf_im || (q_im > (tail.neg_im ? LIM_NEG : LIM_POS));
        dq_re   = dsat_re ? (tail.neg_re ? VMIN : VMAX)
                          : DW'(tail.neg_re ? -q_re : q_re);
        dq_im   = dsat_im ? (tail.neg_im ? VMIN : VMAX)
                          : DW'(tail.neg_im ? -q_im : q_im);
        done_next = tail.valid;
        eq_next   = tail.eq;
        dz_next   = tail.dz;
        if (tail.is_div)
        begin
            re_next  = dq_re;
            im_next  = dq_im;
            sat_next = dsat_re | dsat_im;
        end
        else
        begin
            re_next  = sre_reg[QW-1];
            im_next  = sim_reg[QW-1];
            sat_next = tail.sat;
        end
    end

    logic          done_reg, eq_reg, dz_reg, sat_reg;
    logic [DW-1:0] re_reg, im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        re_reg  <= re_next;
        im_reg  <= im_next;
        eq_reg  <= eq_next;
        dz_reg  <= dz_next;
        sat_reg <= sat_next;
    end

    assign done        = done_reg;
    assign result_real = signed'(re_reg);
    assign result_imag = signed'(im_reg);
    assign is_equal    = eq_reg;
    assign div_by_zero = dz_reg;
    assign saturated   = sat_reg;

endmodule

// ===== rtl/cau_div_cell.sv =====
// one restoring division step for the real and imaginary quotients
// depends on nothing; chained by complex_arith_unit
module cau_div_cell #(
    parameter int PW = 32,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic [PW-1:0] den_in,
    input  logic [PW-1:0] rem_re_in,
    input  logic [PW-1:0] rem_im_in,
    input  logic [QW-1:0] low_re_in,
    input  logic [QW-1:0] low_im_in,
    input  logic [QW-1:0] quo_re_in,
    input  logic [QW-1:0] quo_im_in,
    output logic [PW-1:0] den_out,
    output logic [PW-1:0] rem_re_out,
    output logic [PW-1:0] rem_im_out,
    output logic [QW-1:0] low_re_out,
    output logic [QW-1:0] low_im_out,
    output logic [QW-1:0] quo_re_out,
    output logic [QW-1:0] quo_im_out
);

    logic [PW:0]   try_re, try_im;
    logic          ge_re, ge_im;
    logic [PW-1:0] rem_re_next, rem_im_next;

    // shift in the next numerator bit and trial subtract
    always_comb
    begin
        try_re      = {rem_re_in, low_re_in[QW-1]};
        try_im      = {rem_im_in, low_im_in[QW-1]};
        ge_re       = try_re >= {1'b0, den_in};
        ge_im       = try_im >= {1'b0, den_in};
        rem_re_next = ge_re ? PW'(try_re - {1'b0, den_in}) : PW'(try_re);
        rem_im_next = ge_im ? PW'(try_im - {1'b0, den_in}) : PW'(try_im);
    end

    // hand the step to the neighbor
    always_ff @(posedge clk)
    begin
        den_out    <= den_in;
        rem_re_out <= rem_re_next;
        rem_im_out <= rem_im_next;
        low_re_out <= {low_re_in[QW-2:0], 1'b0};
        low_im_out <= {low_im_in[QW-2:0], 1'b0};
        quo_re_out <= {quo_re_in[QW-2:0], ge_re};
        quo_im_out <= {quo_im_in[QW-2:0], ge_im};
    end

endmodule

// ===== rtl/cau_checker.sv =====
// port-level checker for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arith_unit_macros.svh
`include "complex_arith_unit_macros.svh"

module cau_checker
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [DATA_WIDTH-1:0] result_real,
    input logic [DATA_WIDTH-1:0] result_imag,
    input logic                  is_equal,
    input logic                  div_by_zero,
    input logic                  saturated
);

    localparam int LAT = latency(DATA_WIDTH);

    // every accepted beat returns exactly one result after the fixed latency,
    // checked once the whole window lies after reset
    `CAU_ASSERT_IMP(a_latency, $past(rst_n, LAT), done == $past(start && !busy, LAT))
    // the unit never refuses a command
    `CAU_ASSERT_ALWAYS(a_no_busy, !busy)
    // division by zero gives a zero result and no other flag
    `CAU_ASSERT_IMP(a_dz_zero, done && div_by_zero, (result_real == '0) && (result_imag == '0) && !saturated && !is_equal)
    // a compare match carries a zero result and no other flag
    `CAU_ASSERT_IMP(a_eq_zero, done && is_equal, (result_real == '0) && (result_imag == '0) && !saturated && !div_by_zero)

endmodule

bind complex_arith_unit cau_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .result_real (result_real),
    .result_imag (result_imag),
    .is_equal    (is_equal),
    .div_by_zero (div_by_zero),
    .saturated   (saturated)
);

// ===== dv/complex_arith_unit_tb.sv =====
// self-checking testbench of the complex arithmetic unit: directed table, then random beats
// depends on cau_pkg and the complex_arith_unit rtl
module complex_arith_unit_tb;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW   = 16;
    localparam int FB   = 12;
    localparam int NRND = 1850;
    localparam logic signed [DW-1:0] SMAX = 16'sh7fff;
    localparam logic signed [DW-1:0] SMIN = 16'sh8000;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 eq;
        logic                 dz;
        logic                 sat;
    } cplx_res_t;

    typedef struct {
        logic [2:0]           op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
        bit                   fixed;
        cplx_res_t            res;
    } cmd_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           action;
    logic signed [DW-1:0] a_real;
    logic signed [DW-1:0] a_imag;
    logic signed [DW-1:0] b_real;
    logic signed [DW-1:0] b_imag;
    logic                 done;
    logic signed [DW-1:0] result_real;
    logic signed [DW-1:0] result_imag;
    logic                 is_equal;
    logic                 div_by_zero;
    logic                 saturated;

    cplx_res_t pending_results[$];
    int        error_count = 0;

    complex_arith_unit #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .a_real      (a_real),
        .a_imag      (a_imag),
        .b_real      (b_real),
        .b_imag      (b_imag),
        .done        (done),
        .result_real (result_real),
        .result_imag (result_imag),
        .is_equal    (is_equal),
        .div_by_zero (div_by_zero),
        .saturated   (saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // clamp a wide value to the signed part range
    function automatic logic signed [DW-1:0] clamp_part(input logic signed [63:0] x,
                                                         inout logic sat);
        if (x > 64'sd32767)
        begin
            sat = 1'b1;
            return SMAX;
        end
        if (x < -64'sd32768)
        begin
            sat = 1'b1;
            return SMIN;
        end
        return x[DW-1:0];
    endfunction

    // fixed point quotient num * 2^FB / den, truncated toward zero
    function automatic logic signed [DW-1:0] fix_quot(input logic signed [63:0] num,
                                                       input logic signed [63:0] den,
                                                       inout logic sat);
        logic signed [63:0] q;
        q = (num * 64'sd4096) / den;
        return clamp_part(q, sat);
    endfunction

    // expected result of one command beat
    function automatic cplx_res_t complex_result(input logic [2:0] op,
                                                 input logic signed [DW-1:0] ar,
                                                 input logic signed [DW-1:0] ai,
                                                 input logic signed [DW-1:0] br,
                                                 input logic signed [DW-1:0] bi);
        cplx_res_t          r;
        logic signed [63:0] xr, xi, xbr, xbi, den;
        logic               s;
        r   = '0;
        s   = 1'b0;
        xr  = ar;
        xi  = ai;
        xbr = br;
        xbi = bi;
        case (op)
            ACT_ADD:
            begin
                r.re = clamp_part(xr + xbr, s);
                r.im = clamp_part(xi + xbi, s);
            end
            ACT_SUB:
            begin
                r.re = clamp_part(xr - xbr, s);
                r.im = clamp_part(xi - xbi, s);
            end
            ACT_MUL:
            begin
                r.re = clamp_part((xr * xbr - xi * xbi) >>> FB, s);
                r.im = clamp_part((xi * xbr + xbi * xr) >>> FB, s);
            end
            ACT_DIV:
            begin
                den = xbr * xbr + xbi * xbi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = fix_quot(xr * xbr + xi * xbi, den, s);
                    r.im = fix_quot(xi * xbr - xbi * xr, den, s);
                end
            end
            ACT_CONJ:
            begin
                r.re = ar;
                r.im = clamp_part(-xi, s);
            end
            ACT_CMP:
                r.eq = (ar == br) && (ai == bi);
            default:
                ;
        endcase
        r.sat = s;
        return r;
    endfunction

    // drive one beat and hold it until accepted
    task automatic send_beat(input logic [2:0] op, input logic signed [DW-1:0] ar,
                             input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                             input logic signed [DW-1:0] bi, input bit fixed,
                             input cplx_res_t res, input bit may_idle);
        cplx_res_t want;
        if (may_idle)
        begin
            while ($urandom_range(99) < 25)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        want = complex_result(op, ar, ai, br, bi);
        if (fixed && want !== res)
        begin
            $error("table row for action %0d disagrees with predictor", op);
            error_count++;
        end
        start  <= 1'b1;
        action <= op;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(fixed ? res : want);
        @(negedge clk);
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        cplx_res_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (result_real !== w.re)
                begin
                    $error("result_real expected %0d got %0d", w.re, result_real);
                    error_count++;
                end
                if (result_imag !== w.im)
                begin
                    $error("result_imag expected %0d got %0d", w.im, result_imag);
                    error_count++;
                end
                if (is_equal !== w.eq)
                begin
                    $error("is_equal expected %0b got %0b", w.eq, is_equal);
                    error_count++;
                end
                if (div_by_zero !== w.dz)
                begin
                    $error("div_by_zero expected %0b got %0b", w.dz, div_by_zero);
                    error_count++;
                end
                if (saturated !== w.sat)
                begin
                    $error("saturated expected %0b got %0b", w.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // random operand, biased toward extremes and small values
    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(9))
            0: return SMAX;
            1: return SMIN;
            2: return 16'(int'($urandom_range(16)) - 8);
            3: return 16'($urandom_range(8192)) - 16'sd4096;
            default: return 16'($urandom());
        endcase
    endfunction

    // stimulus
    initial
    begin
        cmd_row_t        rows[$];
        logic signed [DW-1:0] ar, ai, br, bi;
        logic [2:0]      op;
        int              wait_cnt;
        rst_n  = 1'b0;
        start  = 1'b0;
        action = '0;
        a_real = '0;
        a_imag = '0;
        b_real = '0;
        b_imag = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: extremes, every action, saturation, divide by zero, unused codes
        rows = '{
            '{ACT_ADD, SMAX, SMIN, 16'sd1, -16'sd1, 1, '{SMAX, SMIN, 1'b0, 1'b0, 1'b1}},
            '{ACT_ADD, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 1,
              '{16'sd8192, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{ACT_SUB, SMIN, SMAX, 16'sd1, -16'sd1, 1, '{SMIN, SMAX, 1'b0, 1'b0, 1'b1}},
            '{ACT_SUB, SMAX, SMAX, SMAX, SMAX, 1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{ACT_MUL, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 1,
              '{16'sd4096, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{ACT_MUL, SMIN, SMIN, SMIN, SMIN, 0, '0},
            '{ACT_MUL, SMAX, SMIN, SMAX, SMAX, 0, '0},
            '{ACT_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0, 0, '0},
            '{ACT_DIV, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 1,
              '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0}},
            '{ACT_DIV, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 1,
              '{16'sd4096, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{ACT_DIV, SMAX, SMIN, 16'sd1, 16'sd0, 0, '0},
            '{ACT_DIV, SMIN, SMIN, SMIN, SMIN, 0, '0},
            '{ACT_DIV, -16'sd1, 16'sd3, SMAX, 16'sd7, 0, '0},
            '{ACT_CONJ, SMIN, SMIN, 16'sd0, 16'sd0, 1, '{SMIN, SMAX, 1'b0, 1'b0, 1'b1}},
            '{ACT_CONJ, SMAX, SMAX, 16'sd0, 16'sd0, 1, '{SMAX, -SMAX, 1'b0, 1'b0, 1'b0}},
            '{ACT_CMP, SMIN, SMAX, SMIN, SMAX, 1, '{16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
            '{ACT_CMP, SMIN, SMAX, SMIN, SMIN, 1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
            '{3'd6, SMAX, SMAX, SMAX, SMAX, 1, '0},
            '{3'd7, SMIN, SMIN, SMIN, SMIN, 1, '0}
        };
        foreach (rows[k])
            send_beat(rows[k].op, rows[k].ar, rows[k].ai, rows[k].br, rows[k].bi,
                      rows[k].fixed, rows[k].res, k % 3 == 0);

        // random beats; the middle stretch runs back to back
        for (int n = 0; n < NRND; n++)
        begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                            : 3'($urandom_range(5));
            ar = rand_part();
            ai = rand_part();
            br = rand_part();
            bi = rand_part();
            if (op == ACT_CMP && $urandom_range(1))
            begin
                br = ar;
                if ($urandom_range(1))
                    bi = ai;
            end
            if (op == ACT_DIV && $urandom_range(9) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_beat(op, ar, ai, br, bi, 0, '0, !(n >= 600 && n < 900));
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (latency(DW) + 4) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[complex_arith_unit] OK");
        else
            $display("[complex_arith_unit] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #500us;
        $display("[complex_arith_unit] ERROR");
        $finish;
    end

endmodule
